### sv/biased_lattice_walker_step_macros.svh
// ---------------------------------------------------------------------------
// biased_lattice_walker_step assertion macros
// Concurrent check wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BIASED_LATTICE_WALKER_STEP_MACROS_SVH
`define BIASED_LATTICE_WALKER_STEP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, expects clk and rst_n in scope
`define BLWS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("blws check failed");
// next-cycle implication
`define BLWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("blws check failed");
`else
`define BLWS_ASSERT_IMPL(label, ante, cons)
`define BLWS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### sv/blws_pkg.sv
// ---------------------------------------------------------------------------
// blws_pkg
// Shared widths, codes and types of the lattice walker block.
// ---------------------------------------------------------------------------
package blws_pkg;

  localparam int WALKER_INDEX_W  = 10;
  localparam int COORD_X_W       = 32;
  localparam int COORD_W         = 16;
  localparam int COUNT_W         = 32;
  localparam int FRAC_W          = 32;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int NUM_WALKERS_DEF = 1024;

  localparam logic ACT_INIT = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_THRESH_PLUS_X  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESH_MINUS_X = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESH_PLUS_Y  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESH_MINUS_Y = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESH_PLUS_Z  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_Y       = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_Z       = 3'd6;

  typedef struct packed {
    logic [FRAC_W-1:0]  thresh_plus_x;
    logic [FRAC_W-1:0]  thresh_minus_x;
    logic [FRAC_W-1:0]  thresh_plus_y;
    logic [FRAC_W-1:0]  thresh_minus_y;
    logic [FRAC_W-1:0]  thresh_plus_z;
    logic [COORD_W-1:0] period_y;
    logic [COORD_W-1:0] period_z;
  } cfg_t;

  typedef struct packed {
    logic [COORD_X_W-1:0] x;
    logic [COORD_W-1:0]   y;
    logic [COORD_W-1:0]   z;
    logic [COUNT_W-1:0]   taken;
    logic [COUNT_W-1:0]   target;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### sv/blws_in_if.sv
// ---------------------------------------------------------------------------
// blws_in_if
// Input item channel: init or step request for one walker.
// ---------------------------------------------------------------------------
interface blws_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [blws_pkg::WALKER_INDEX_W-1:0] walker_index;
  logic [blws_pkg::COUNT_W-1:0]        target_steps;
  logic [blws_pkg::FRAC_W-1:0]         random_fraction;

  modport source (output valid, action, walker_index, target_steps, random_fraction,
                  input ready);
  modport sink   (input valid, action, walker_index, target_steps, random_fraction,
                  output ready);
endinterface

### sv/blws_out_if.sv
// ---------------------------------------------------------------------------
// blws_out_if
// Result item channel: walker position and activity after an item.
// ---------------------------------------------------------------------------
interface blws_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [blws_pkg::WALKER_INDEX_W-1:0]  walker_index_out;
  logic signed [blws_pkg::COORD_X_W-1:0] pos_x;
  logic [blws_pkg::COORD_W-1:0]         pos_y;
  logic [blws_pkg::COORD_W-1:0]         pos_z;
  logic                                 active;

  modport source (output valid, walker_index_out, pos_x, pos_y, pos_z, active,
                  input ready);
  modport sink   (input valid, walker_index_out, pos_x, pos_y, pos_z, active,
                  output ready);
endinterface

### sv/blws_ram.sv
// ---------------------------------------------------------------------------
// blws_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module blws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/blws_update.sv
// ---------------------------------------------------------------------------
// blws_update
// Next walker entry for an init or step item, plus the activity flag.
// ---------------------------------------------------------------------------
module blws_update (
  input  blws_pkg::cfg_t                cfg,
  input  blws_pkg::entry_t              cur,
  input  logic                          action,
  input  logic [blws_pkg::COUNT_W-1:0]  target_steps,
  input  logic [blws_pkg::FRAC_W-1:0]   random_fraction,
  output blws_pkg::entry_t              nxt,
  output logic                          active
);

  localparam int CW = blws_pkg::COORD_W;

  function automatic logic [CW-1:0] eff_period(input logic [CW-1:0] p);
    return (p == '0) ? CW'(1) : p;
  endfunction

  function automatic logic [CW-1:0] wrap_up(input logic [CW-1:0] c, input logic [CW-1:0] p);
    logic [CW:0] n;
    n = {1'b0, c} + (CW+1)'(1);
    return (n >= {1'b0, p}) ? '0 : n[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] wrap_down(input logic [CW-1:0] c,
                                                input logic [CW-1:0] p);
    return (c == '0 || c > p) ? p - CW'(1) : c - CW'(1);
  endfunction

  logic [CW-1:0]                 py;
  logic [CW-1:0]                 pz;
  logic                          can_move;
  logic [blws_pkg::COUNT_W:0]    taken_inc;

  assign py        = eff_period(cfg.period_y);
  assign pz        = eff_period(cfg.period_z);
  assign can_move  = cur.taken < cur.target;
  assign taken_inc = {1'b0, cur.taken} + (blws_pkg::COUNT_W+1)'(1);

  always_comb begin
    nxt    = cur;
    active = 1'b0;
    if (action == blws_pkg::ACT_INIT) begin
      nxt.x      = '0;
      nxt.y      = '0;
      nxt.z      = '0;
      nxt.taken  = '0;
      nxt.target = target_steps;
      active     = target_steps != '0;
    end else if (can_move) begin
      // first threshold that the fraction falls below picks the move
      if (random_fraction < cfg.thresh_plus_x) begin
        nxt.x = cur.x + blws_pkg::COORD_X_W'(1);
      end else if (random_fraction < cfg.thresh_minus_x) begin
        nxt.x = cur.x - blws_pkg::COORD_X_W'(1);
      end else if (random_fraction < cfg.thresh_plus_y) begin
        nxt.y = wrap_up(cur.y, py);
      end else if (random_fraction < cfg.thresh_minus_y) begin
        nxt.y = wrap_down(cur.y, py);
      end else if (random_fraction < cfg.thresh_plus_z) begin
        nxt.z = wrap_up(cur.z, pz);
      end else begin
        nxt.z = wrap_down(cur.z, pz);
      end
      nxt.taken = taken_inc[blws_pkg::COUNT_W-1:0];
      active    = taken_inc < {1'b0, cur.target};
    end
  end

endmodule

### sv/biased_lattice_walker_step.sv
// ---------------------------------------------------------------------------
// biased_lattice_walker_step
// Walker table on a 3D lattice with biased steps, periodic in y and z.
// ---------------------------------------------------------------------------
// Takes one item per clock when the result side keeps up. Each item is a
// single read-modify-write of the walker RAM (position, step count and
// target in one 128-bit word): the entry is read in the accept cycle, updated
// and written back when the update stage advances, the result going into the
// output register with it. A write-back to the entry being read in the
// same cycle is forwarded, so items on the same walker may follow directly.
// Walker entries hold nothing useful until an init item has written them;
// there is no clearing pass after reset. Items whose index lies beyond the
// table touch nothing and report a zero position, inactive.
`include "biased_lattice_walker_step_macros.svh"

module biased_lattice_walker_step #(
  parameter int NUM_WALKERS = blws_pkg::NUM_WALKERS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  blws_in_if.sink                          in_ch,
  blws_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [blws_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [blws_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IW = blws_pkg::WALKER_INDEX_W;
  localparam int AW = (NUM_WALKERS > 1) ? $clog2(NUM_WALKERS) : 1;
  localparam int XW = AW + IW;

  // configuration registers
  blws_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thresh_plus_x  <= '0;
      cfg_r.thresh_minus_x <= '0;
      cfg_r.thresh_plus_y  <= '0;
      cfg_r.thresh_minus_y <= '0;
      cfg_r.thresh_plus_z  <= '0;
      cfg_r.period_y       <= blws_pkg::COORD_W'(1);
      cfg_r.period_z       <= blws_pkg::COORD_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        blws_pkg::REG_THRESH_PLUS_X:  cfg_r.thresh_plus_x  <= cfg_wdata;
        blws_pkg::REG_THRESH_MINUS_X: cfg_r.thresh_minus_x <= cfg_wdata;
        blws_pkg::REG_THRESH_PLUS_Y:  cfg_r.thresh_plus_y  <= cfg_wdata;
        blws_pkg::REG_THRESH_MINUS_Y: cfg_r.thresh_minus_y <= cfg_wdata;
        blws_pkg::REG_THRESH_PLUS_Z:  cfg_r.thresh_plus_z  <= cfg_wdata;
        blws_pkg::REG_PERIOD_Y:  cfg_r.period_y <= cfg_wdata[blws_pkg::COORD_W-1:0];
        blws_pkg::REG_PERIOD_Z:  cfg_r.period_z <= cfg_wdata[blws_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // accept stage
  logic          in_acc;
  logic [XW-1:0] in_idx_ext;
  logic [AW-1:0] in_addr;
  logic          in_inrange;

  // update stage
  logic                            s1_valid_r, s1_valid_nxt;
  logic                            s1_action_r;
  logic [IW-1:0]                   s1_index_r;
  logic [AW-1:0]                   s1_addr_r;
  logic                            s1_inrange_r;
  logic [blws_pkg::COUNT_W-1:0]    s1_target_r;
  logic [blws_pkg::FRAC_W-1:0]     s1_rand_r;
  logic                            s1_adv;

  logic                            fwd_valid_r, fwd_valid_nxt;
  blws_pkg::entry_t                fwd_entry_r;

  logic [blws_pkg::ENTRY_W-1:0]    ram_rdata;
  logic                            ram_we;
  blws_pkg::entry_t                entry_cur;
  blws_pkg::entry_t                entry_new;
  logic                            active_new;

  // output register
  logic                                  out_valid_r, out_valid_nxt;
  logic [IW-1:0]                         out_index_r;
  logic [blws_pkg::COORD_X_W-1:0]        out_x_r;
  logic [blws_pkg::COORD_W-1:0]          out_y_r;
  logic [blws_pkg::COORD_W-1:0]          out_z_r;
  logic                                  out_active_r;

  assign in_idx_ext = XW'(in_ch.walker_index);
  assign in_addr    = in_idx_ext[AW-1:0];
  assign in_inrange = in_idx_ext < XW'(NUM_WALKERS);

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign ram_we      = s1_valid_r && s1_adv && s1_inrange_r;

  assign entry_cur = fwd_valid_r ? fwd_entry_r : blws_pkg::entry_t'(ram_rdata);

  blws_ram #(
    .WIDTH (blws_pkg::ENTRY_W),
    .DEPTH (NUM_WALKERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (entry_new),
    .re    (in_acc),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  blws_update u_update (
    .cfg             (cfg_r),
    .cur             (entry_cur),
    .action          (s1_action_r),
    .target_steps    (s1_target_r),
    .random_fraction (s1_rand_r),
    .nxt             (entry_new),
    .active          (active_new)
  );

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    fwd_valid_nxt = fwd_valid_r;
    if (in_acc) begin
      s1_valid_nxt  = 1'b1;
      // the ram read misses a write to the same entry in this cycle
      fwd_valid_nxt = ram_we && (s1_addr_r == in_addr);
    end else if (s1_adv) begin
      s1_valid_nxt  = 1'b0;
      fwd_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_valid_r && s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      fwd_valid_r <= fwd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r  <= in_ch.action;
      s1_index_r   <= in_ch.walker_index;
      s1_addr_r    <= in_addr;
      s1_inrange_r <= in_inrange;
      s1_target_r  <= in_ch.target_steps;
      s1_rand_r    <= in_ch.random_fraction;
      fwd_entry_r  <= entry_new;
    end
    if (s1_valid_r && s1_adv) begin
      out_index_r <= s1_index_r;
      if (s1_inrange_r) begin
        out_x_r      <= entry_new.x;
        out_y_r      <= entry_new.y;
        out_z_r      <= entry_new.z;
        out_active_r <= active_new;
      end else begin
        out_x_r      <= '0;
        out_y_r      <= '0;
        out_z_r      <= '0;
        out_active_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.walker_index_out = out_index_r;
  assign out_ch.pos_x            = $signed(out_x_r);
  assign out_ch.pos_y            = out_y_r;
  assign out_ch.pos_z            = out_z_r;
  assign out_ch.active           = out_active_r;

  `BLWS_ASSERT_IMPL(a_fwd_needs_item, fwd_valid_r, s1_valid_r)
  `BLWS_ASSERT_NEXT(a_adv_fills_out, s1_valid_r && s1_adv, out_valid_r)
  `BLWS_ASSERT_NEXT(a_oob_reports_zero, s1_valid_r && s1_adv && !s1_inrange_r, out_ch.pos_x == 0 && !out_ch.active)

endmodule
